// ===== src/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared constants, codes and types for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int VALUE_W       = 32;
  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int POSITION_W    = 4;
  localparam int COUNT_OUT_W   = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } slt_ctl_t;

endpackage

// ===== src/slt_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one entry, compares it with the incoming value and shifts with its
// neighbors on an insert or a remove.
// ----------------------------------------------------------------------------
module slt_cell
  import slt_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  slt_ctl_t           ctl,
  input  logic [VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]   count,
  input  logic [VALUE_W-1:0] left_val,
  input  logic               left_less,
  input  logic               left_eq,
  input  logic [VALUE_W-1:0] right_val,
  output logic [VALUE_W-1:0] val,
  output logic               less,
  output logic               eq,
  output logic               ge_mark,
  output logic               eq_mark
);

  logic [VALUE_W-1:0] stored;
  logic               held;

  assign held    = count > CNT_W'(INDEX);
  assign less    = held && ($signed(stored) < $signed(value));
  assign eq      = held && (stored == value);
  assign ge_mark = !less && left_less;
  assign eq_mark = eq && !left_eq;
  assign val     = stored;

  always_ff @(posedge clk) begin
    if (ctl.insert_en && !less) begin
      stored <= ge_mark ? value : left_val;
    end else if (ctl.remove_en && !less) begin
      stored <= right_val;
    end
  end

endmodule

// ===== src/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// Sorted list table
// Bounded table of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries an action (insert, remove first
// match, search first match) and a value. Each accepted beat yields exactly
// one output beat on the m_ channel with a status, the position of the entry
// that was inserted, removed or found, and the entry count after the action.
// The entries sit in a row of cells; every cell compares its entry with the
// value at once, and on an insert or a remove the cells above the affected
// position shift by one toward their neighbor in the same cycle.
// Output beats are registered; each appears the cycle after its input beat
// is accepted. One beat is taken per cycle. The clock is set by the 32-bit
// compare in each cell followed by the position encoder across all cells.
// Reset empties the table and drops any pending output beat; no clearing
// pass is needed. When the receiver stalls, the output beat is held and
// s_tready falls until it is taken.
// ----------------------------------------------------------------------------
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], position[5:2], entry_count[10:6]
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = (IDX_W > POSITION_W) ? IDX_W : POSITION_W;
  localparam int CXW   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  logic                s_accept;
  logic [ACTION_W-1:0] in_action;
  logic [VALUE_W-1:0]  in_value;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                full;
  logic                hit;
  slt_ctl_t            ctl;

  logic [VALUE_W-1:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]    less;
  logic [DEPTH-1:0]    eq;
  logic [DEPTH-1:0]    ge_mark;
  logic [DEPTH-1:0]    eq_mark;

  logic [PW-1:0]       ge_idx;
  logic [PW-1:0]       eq_idx;
  logic [PW-1:0]       pos_wide;
  logic [STATUS_W-1:0] status_next;
  logic [CXW-1:0]      count_ext;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [POSITION_W-1:0] out_pos;
  logic [COUNT_OUT_W-1:0] out_count;

  assign in_action = s_tdata[1:0];
  assign in_value  = s_tdata[33:2];
  assign s_tready  = !out_valid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign full      = count == CNT_W'(DEPTH);
  assign hit       = |eq_mark;

  assign ctl.insert_en = s_accept && (in_action == ACT_INSERT) && !full;
  assign ctl.remove_en = s_accept && (in_action == ACT_REMOVE) && hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_val;
    logic [VALUE_W-1:0] right_val;
    logic               left_less;
    logic               left_eq;

    if (i == 0) begin : g_first
      assign left_val  = in_value;
      assign left_less = 1'b1;
      assign left_eq   = 1'b0;
    end else begin : g_inner
      assign left_val  = cell_val[i-1];
      assign left_less = less[i-1];
      assign left_eq   = eq[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    slt_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .value     (in_value),
      .count     (count),
      .left_val  (left_val),
      .left_less (left_less),
      .left_eq   (left_eq),
      .right_val (right_val),
      .val       (cell_val[i]),
      .less      (less[i]),
      .eq        (eq[i]),
      .ge_mark   (ge_mark[i]),
      .eq_mark   (eq_mark[i])
    );
  end

  always_comb begin
    ge_idx = '0;
    eq_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ge_mark[i]) begin
        ge_idx = ge_idx | PW'(i);
      end
      if (eq_mark[i]) begin
        eq_idx = eq_idx | PW'(i);
      end
    end
  end

  always_comb begin
    status_next = STAT_NOT_FOUND;
    pos_wide    = '0;
    count_next  = count;
    unique case (in_action)
      ACT_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          status_next = STAT_DONE;
          pos_wide    = ge_idx;
          count_next  = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          status_next = STAT_DONE;
          pos_wide    = eq_idx;
          count_next  = count - CNT_W'(1);
        end
      end
      ACT_SEARCH: begin
        if (hit) begin
          status_next = STAT_DONE;
          pos_wide    = eq_idx;
        end
      end
      default: begin
        status_next = STAT_NOT_FOUND;
      end
    endcase
  end

  assign count_ext = CXW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_status <= status_next;
      out_pos    <= pos_wide[POSITION_W-1:0];
      out_count  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_count, out_pos, out_status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_en |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the entry count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.remove_en |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the entry count");

  a_marks_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ge_mark) && $onehot0(eq_mark))
    else $error("more than one cell claims the position");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> m_tvalid)
    else $error("accepted beat produced no output beat");

endmodule
